// ===== design/psam_pkg.sv =====
`default_nettype none

package psam_pkg;

    // fixed field widths
    localparam int ADC_W     = 12;
    localparam int AXIS_W    = 8;
    localparam int CFG_IDX_W = 2;
    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 8;

    // averaging depth, allowed range 1..64
    localparam int AVG_SAMPLES_DEF = 4;

    // divider widths: dividend of the mapping step is 2*|num| + span (21 bits),
    // divisor is 2*span (13 bits)
    localparam int MAP_DVD_W = 21;
    localparam int DVS_W     = 13;

    localparam logic [AXIS_W-1:0] AXIS_TOP = 8'sd127;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADC_MIN  = 2'd0,
        CFG_ADC_MAX  = 2'd1,
        CFG_END_SNAP = 2'd2,
        CFG_INVERT   = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        K_ZERO = 2'd0,
        K_LOW  = 2'd1,
        K_HIGH = 2'd2,
        K_LIN  = 2'd3
    } t_kind;

    // controller -> datapath
    typedef struct packed {
        logic  acc;        // sample taken this cycle
        logic  div_start;  // launch divider
        logic  raw_load;   // capture group mean
        logic  eval;       // capture zone decision and mapping operands
        logic  out_load;   // write result register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic grp_last;    // next sample closes the group
        logic div_done;    // quotient ready
        logic div_busy;
        logic lin;         // linear range, needs the division
        logic out_free;    // result register can take a value
    } t_stat;

endpackage

`default_nettype wire

// ===== design/psam_div.sv =====
`default_nettype none

module psam_div #(
    parameter int DVD_W = 21,
    parameter int DVS_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [DVD_W-1:0] i_dividend,
    input  wire logic [DVS_W-1:0] i_divisor,
    output logic      [DVD_W-1:0] o_quot,
    output logic                  o_busy,
    output logic                  o_done
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_quo;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;
    logic             ge;

    // restoring step, one quotient bit per cycle
    always_comb begin
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        ge      = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], ge};
        end
    end

    assign o_quot = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== design/psam_dp.sv =====
`default_nettype none

module psam_dp #(
    parameter int AVG_SAMPLES = 4,
    parameter int SUM_W       = 14,
    parameter int CNT_W       = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire psam_pkg::t_cmd                   i_cmd,
    output psam_pkg::t_stat                       o_stat,
    input  wire logic [psam_pkg::ADC_W-1:0]       i_sample,
    input  wire logic                             i_cfg_we,
    input  wire logic [psam_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [psam_pkg::ADC_W-1:0]       i_cfg_data,
    input  wire logic                             i_out_ready,
    output logic                                  o_out_valid,
    output logic      [psam_pkg::AXIS_W-1:0]      o_out_data
);
    import psam_pkg::*;

    // group mean by reciprocal multiplication, exact for every group sum
    localparam int MEAN_SH  = SUM_W + $clog2(AVG_SAMPLES);
    localparam int MEAN_M_I = ((1 << MEAN_SH) + AVG_SAMPLES - 1) / AVG_SAMPLES;
    localparam logic [SUM_W:0] MEAN_M = (SUM_W+1)'(MEAN_M_I);
    localparam int PROD_W   = 2 * SUM_W + 1;

    logic [ADC_W-1:0]     r_adc_min;
    logic [ADC_W-1:0]     r_adc_max;
    logic [ADC_W-1:0]     r_end_snap;
    logic                 r_invert;

    logic [SUM_W-1:0]     r_sum;
    logic [CNT_W-1:0]     r_cnt;
    logic [SUM_W-1:0]     r_grp;
    logic [ADC_W-1:0]     r_raw;
    t_kind                r_kind;
    logic                 r_neg;
    logic [MAP_DVD_W-1:0] r_num;
    logic [DVS_W-1:0]     r_den;
    logic                 r_out_valid;
    logic [AXIS_W-1:0]    r_out_data;

    logic [SUM_W-1:0]     sum_nx;
    logic                 grp_last;
    logic [PROD_W-1:0]    mean_prod;

    // zone decision and mapping operands
    logic [ADC_W:0]       lo_plus;
    logic                 low_hit;
    logic signed [ADC_W+1:0] hi_minus;
    logic                 high_hit;
    logic [ADC_W:0]       span13;
    logic                 span_pos;
    logic [ADC_W-1:0]     span;
    logic [ADC_W-1:0]     diff;
    logic [MAP_DVD_W-2:0] p254;
    logic [MAP_DVD_W-2:0] p127;
    logic signed [MAP_DVD_W-1:0] num;
    logic [MAP_DVD_W-1:0] num_abs;
    logic [MAP_DVD_W-1:0] dvd_map;
    t_kind                kind;

    logic [MAP_DVD_W-1:0] div_quot;
    logic                 div_busy;
    logic                 div_done;

    logic [AXIS_W-1:0]    q_mag;
    logic [AXIS_W-1:0]    axis;
    logic                 neg_out;

    assign sum_nx    = r_sum + SUM_W'(i_sample);
    assign grp_last  = (r_cnt == CNT_W'(AVG_SAMPLES - 1));
    assign mean_prod = PROD_W'(r_grp) * PROD_W'(MEAN_M);

    always_comb begin
        lo_plus  = {1'b0, r_adc_min} + {1'b0, r_end_snap};
        low_hit  = {1'b0, r_raw} <= lo_plus;
        hi_minus = $signed({2'b00, r_adc_max}) - $signed({2'b00, r_end_snap});
        high_hit = $signed({2'b00, r_raw}) >= hi_minus;
        span13   = {1'b0, r_adc_max} - {1'b0, r_adc_min};
        span_pos = !span13[ADC_W] && (span13 != '0);
        span     = span13[ADC_W-1:0];
        diff     = r_raw - r_adc_min;
        p254     = (MAP_DVD_W-1)'(diff) * (MAP_DVD_W-1)'(254);
        p127     = (MAP_DVD_W-1)'(span) * (MAP_DVD_W-1)'(127);
        num      = $signed({1'b0, p254}) - $signed({1'b0, p127});
        num_abs  = num[MAP_DVD_W-1] ? MAP_DVD_W'(-num) : MAP_DVD_W'(num);
        dvd_map  = {num_abs[MAP_DVD_W-2:0], 1'b0} + MAP_DVD_W'(span);
        if (!span_pos) begin
            kind = K_ZERO;
        end else if (low_hit) begin
            kind = K_LOW;
        end else if (high_hit) begin
            kind = K_HIGH;
        end else begin
            kind = K_LIN;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adc_min  <= '0;
            r_adc_max  <= '1;
            r_end_snap <= '0;
            r_invert   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ADC_MIN:  r_adc_min  <= i_cfg_data;
                CFG_ADC_MAX:  r_adc_max  <= i_cfg_data;
                CFG_END_SNAP: r_end_snap <= i_cfg_data;
                CFG_INVERT:   r_invert   <= i_cfg_data[0];
                default:      r_invert   <= r_invert;
            endcase
        end
    end

    // group accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.acc) begin
            if (grp_last) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= sum_nx;
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.acc && grp_last) begin
            r_grp <= sum_nx;
        end
        if (i_cmd.raw_load) begin
            r_raw <= mean_prod[MEAN_SH +: ADC_W];
        end
        if (i_cmd.eval) begin
            r_kind <= kind;
            r_neg  <= num[MAP_DVD_W-1];
            r_num  <= dvd_map;
            r_den  <= {span, 1'b0};
        end
    end

    // serial divider for the linear mapping
    psam_div #(
        .DVD_W (MAP_DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_num),
        .i_divisor  (r_den),
        .o_quot     (div_quot),
        .o_busy     (div_busy),
        .o_done     (div_done)
    );

    // final axis value
    always_comb begin
        q_mag   = (div_quot > MAP_DVD_W'(AXIS_TOP)) ? AXIS_TOP : div_quot[AXIS_W-1:0];
        neg_out = r_neg ^ r_invert;
        case (r_kind)
            K_ZERO:  axis = '0;
            K_LOW:   axis = r_invert ? AXIS_TOP : -AXIS_TOP;
            K_HIGH:  axis = r_invert ? -AXIS_TOP : AXIS_TOP;
            K_LIN:   axis = neg_out ? -q_mag : q_mag;
            default: axis = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= axis;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign o_stat.grp_last = grp_last;
    assign o_stat.div_done = div_done;
    assign o_stat.div_busy = div_busy;
    assign o_stat.lin      = (r_kind == K_LIN);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// ===== design/psam_ctrl.sv =====
`default_nettype none

module psam_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire psam_pkg::t_stat i_stat,
    output psam_pkg::t_cmd       o_cmd
);
    import psam_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_EVAL,
        S_MAP_GO,
        S_MAP_WAIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_in_ready = (r_state == S_IDLE);
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.acc = take;
                if (take && i_stat.grp_last) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.raw_load = 1'b1;
                n_state        = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_MAP_GO;
            end
            S_MAP_GO: begin
                if (i_stat.lin) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_MAP_WAIT;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MAP_WAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/pot_sample_to_axis_mapper_core.sv =====
// channel     | direction | handshake                     | payload
// s_axis      | in        | s_axis_tvalid / s_axis_tready | tdata[11:0] adc_sample
// m_axis      | out       | m_axis_tvalid / m_axis_tready | tdata[7:0]  axis_value
// cfg write   | in        | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// a sample that does not close a group is taken while the input stays open
// a group-closing sample holds the input through mean by reciprocal multiply, zone
// decision, one-bit-per-cycle division (linear range only; a snap zone or empty
// calibration skips it) and result write, which waits for the previous result
// reset is synchronous, active low, and clears the group, the config and the result
// a waiting result does not block further samples; only a new group result stalls
// until the previous one is taken
`default_nettype none

module pot_sample_to_axis_mapper_core #(
    parameter int AVG_SAMPLES = psam_pkg::AVG_SAMPLES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // s_axis tdata: [11:0] adc_sample, [15:12] zero
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [psam_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    // m_axis tdata: [7:0] axis_value
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [psam_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [psam_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [psam_pkg::ADC_W-1:0]          i_cfg_data
);
    import psam_pkg::*;

    // group sum and sample counter widths follow the averaging depth
    localparam int SUM_W  = ADC_W + $clog2(AVG_SAMPLES);
    localparam int CNT_W  = (AVG_SAMPLES > 1) ? $clog2(AVG_SAMPLES) : 1;

    t_cmd  cmd;
    t_stat stat;

    // config is always accepted
    assign o_cfg_ready = 1'b1;

    psam_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    psam_dp #(
        .AVG_SAMPLES (AVG_SAMPLES),
        .SUM_W       (SUM_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_sample    (s_axis_tdata[ADC_W-1:0]),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // the saturated axis never reaches the most negative code
    a_no_min_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 8'h80))
        else $error("axis value out of range");

    // no sample is taken while the divider is running
    a_ready_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !stat.div_busy)
        else $error("input ready during division");

    // a sample that does not close the group leaves the input open
    a_mid_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !stat.grp_last) |=> s_axis_tready)
        else $error("input stalled inside a group");

    // a result is written only when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_pot_sample_to_axis_mapper_core.sv =====
`timescale 1ns / 100ps

module tb_pot_sample_to_axis_mapper_core;

    import psam_pkg::*;

    localparam int AVG    = AVG_SAMPLES_DEF;
    // a group-closing sample in the linear range runs one serial division
    localparam int SETTLE = 80;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [ADC_W-1:0]       i_cfg_data = '0;

    // mirror of the calibration registers, reset values
    logic [ADC_W-1:0] cal_min  = '0;
    logic [ADC_W-1:0] cal_max  = '1;
    logic [ADC_W-1:0] cal_snap = '0;
    logic             cal_inv  = 1'b0;

    // group accumulator mirror
    int grp_sum = 0;
    int grp_cnt = 0;

    logic [ADC_W-1:0]  sample_q[$];
    logic [AXIS_W-1:0] axis_q[$];
    logic [AXIS_W-1:0] want_axis;

    int n_fed    = 0;
    int n_taken  = 0;
    int n_errors = 0;
    int src_wait = 0;
    int snk_wait = 0;
    int src_max_gap = 7;
    int snk_max_gap = 7;

    pot_sample_to_axis_mapper_core #(
        .AVG_SAMPLES(AVG)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // axis position for a group mean under the current calibration
    function automatic logic [AXIS_W-1:0] axis_of_mean(int raw);
        int lo, hi, snap, span, num, ax;
        lo   = int'(cal_min);
        hi   = int'(cal_max);
        snap = int'(cal_snap);
        span = hi - lo;
        // empty or reversed calibration
        if (span <= 0)
            return '0;
        // low zone wins over the high zone when they overlap
        if (raw <= lo + snap) begin
            ax = cal_inv ? 127 : -127;
            return ax[AXIS_W-1:0];
        end
        if (raw >= hi - snap) begin
            ax = cal_inv ? -127 : 127;
            return ax[AXIS_W-1:0];
        end
        num = 254 * (raw - lo) - 127 * span;
        if (num < -127 * span)
            num = -127 * span;
        if (num > 127 * span)
            num = 127 * span;
        // round to nearest, halves away from zero
        if (num >= 0)
            ax = (2 * num + span) / (2 * span);
        else
            ax = -((2 * (-num) + span) / (2 * span));
        if (cal_inv)
            ax = -ax;
        if (ax > 127)
            ax = 127;
        if (ax < -127)
            ax = -127;
        return ax[AXIS_W-1:0];
    endfunction

    // accumulate one sample, queue a position when the group closes
    function automatic void take_sample(logic [ADC_W-1:0] s);
        grp_sum += int'(s);
        grp_cnt++;
        if (grp_cnt == AVG) begin
            axis_q.push_back(axis_of_mean(grp_sum / AVG));
            grp_sum = 0;
            grp_cnt = 0;
        end
    endfunction

    function automatic logic [ADC_W-1:0] clip12(int v);
        if (v < 0)
            return '0;
        if (v > 4095)
            return '1;
        return v[ADC_W-1:0];
    endfunction

    // sample source: one item held until taken, then a random gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_sample(s_axis_tdata[ADC_W-1:0]);
                n_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {{(TDATA_IN_W-ADC_W){1'b0}}, sample_q.pop_front()};
                    src_wait = $urandom_range(0, src_max_gap);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // position sink: compare against the oldest expected position, then stall a while
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (axis_q.size() == 0) begin
                    $display("%0t: axis_value expected none, got %0d", $time,
                             $signed(m_axis_tdata));
                    n_errors++;
                end else begin
                    want_axis = axis_q.pop_front();
                    if (m_axis_tdata !== want_axis) begin
                        $display("%0t: axis_value expected %0d, got %0d", $time,
                                 $signed(want_axis), $signed(m_axis_tdata));
                        n_errors++;
                    end
                end
                snk_wait = $urandom_range(0, snk_max_gap);
            end
            if (snk_wait > 0) begin
                snk_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic push(logic [ADC_W-1:0] s);
        sample_q.push_back(s);
        n_fed++;
    endtask

    // every item taken and every position out, then let the divider settle
    task automatic wait_drained();
        while (n_taken != n_fed || axis_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [ADC_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_ADC_MIN:  cal_min  = val;
            CFG_ADC_MAX:  cal_max  = val;
            CFG_END_SNAP: cal_snap = val;
            CFG_INVERT:   cal_inv  = val[0];
            default: ;
        endcase
    endtask

    task automatic calibrate(int lo, int hi, int snap, int inv_word);
        write_reg(CFG_ADC_MIN, lo[ADC_W-1:0]);
        write_reg(CFG_ADC_MAX, hi[ADC_W-1:0]);
        write_reg(CFG_END_SNAP, snap[ADC_W-1:0]);
        write_reg(CFG_INVERT, inv_word[ADC_W-1:0]);
    endtask

    // groups of jittered samples around a target that moves per group
    task automatic feed(int count);
        int lo, hi, t, jit;
        lo  = (cal_min < cal_max) ? int'(cal_min) : int'(cal_max);
        hi  = (cal_min < cal_max) ? int'(cal_max) : int'(cal_min);
        t   = 0;
        jit = 2;
        for (int k = 0; k < count; k++) begin
            if (k % AVG == 0) begin
                jit = 2;
                case ($urandom_range(0, 9))
                    6, 7: t = $urandom_range(0, 4095);
                    8: begin
                        // land right on the snap zone borders
                        jit = 0;
                        case ($urandom_range(0, 3))
                            0: t = int'(cal_min) + int'(cal_snap);
                            1: t = int'(cal_min) + int'(cal_snap) + 1;
                            2: t = int'(cal_max) - int'(cal_snap);
                            default: t = int'(cal_max) - int'(cal_snap) - 1;
                        endcase
                    end
                    9: begin
                        jit = 0;
                        t = $urandom_range(0, 1) ? 4095 : 0;
                    end
                    default: t = $urandom_range(clip12(lo - 20), clip12(hi + 20));
                endcase
            end
            // now and then a stray sample breaks the group
            if ($urandom_range(0, 15) == 0)
                push(12'($urandom_range(0, 4095)));
            else
                push(clip12(t + int'($urandom_range(0, 2 * jit)) - jit));
        end
    endtask

    initial begin
        int n_items;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: both stops and a near-top linear point
        repeat (AVG) push(12'd0);
        repeat (AVG) push(12'd4095);
        repeat (AVG - 1) push(12'd4095);
        push(12'd4094);
        wait_drained();

        // exact half steps next to each stop, inverted direction
        calibrate(0, 508, 0, 1);
        repeat (AVG) push(12'd1);
        repeat (AVG) push(12'd507);
        wait_drained();

        // zero span
        calibrate(100, 100, 4095, 0);
        push(12'd4095);
        push(12'd0);
        push(12'd4095);
        push(12'd0);
        wait_drained();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: calibrate(0, 4095, 0, 0);
                1: calibrate(4095, 0, 4095, 12'hFFF);
                2: begin
                    n_items = $urandom_range(0, 2000);
                    calibrate(n_items, $urandom_range(n_items + 1, 4095),
                              $urandom_range(0, 50), $urandom_range(0, 1));
                end
                3: begin
                    n_items = $urandom_range(0, 4095);
                    calibrate(n_items, n_items, $urandom_range(0, 4095), 1);
                end
                4: calibrate(1000, 3000, 100, 12'hA51);
                // high zone border below zero, low zone takes everything
                5: calibrate(2000, 2100, 3000, 0);
                6: calibrate(0, 1, 0, 1);
                default: calibrate($urandom_range(0, 4095), $urandom_range(0, 4095),
                                   $urandom_range(0, 4095), $urandom_range(0, 4095));
            endcase
            if (p == 0) begin
                src_max_gap = 0;
                snk_max_gap = 0;
            end else begin
                src_max_gap = (p % 3 == 2) ? 0 : 7;
                snk_max_gap = (p % 3 == 1) ? 0 : 7;
            end
            n_items = 78 + $urandom_range(0, 5);
            feed(n_items / 2);
            // source holds off until every position is out
            wait_drained();
            feed(n_items - n_items / 2);
            wait_drained();
        end

        if (n_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
